>>> src/exptok_pkg.sv
// Package: token codes, character constants, result type and byte classifiers.
package exptok_pkg;

  localparam int POS_BITS  = 16;
  localparam int LINE_BITS = 16;
  localparam int KIND_BITS = 6;

  localparam logic [KIND_BITS-1:0] K_NONE        = 6'd0;
  localparam logic [KIND_BITS-1:0] K_NUMBER      = 6'd2;
  localparam logic [KIND_BITS-1:0] K_STRING      = 6'd3;
  localparam logic [KIND_BITS-1:0] K_ID          = 6'd4;
  localparam logic [KIND_BITS-1:0] K_PLUS        = 6'd5;
  localparam logic [KIND_BITS-1:0] K_PLUSEQUAL   = 6'd6;
  localparam logic [KIND_BITS-1:0] K_MINUS       = 6'd7;
  localparam logic [KIND_BITS-1:0] K_MINUSEQUAL  = 6'd8;
  localparam logic [KIND_BITS-1:0] K_STAR        = 6'd9;
  localparam logic [KIND_BITS-1:0] K_STAREQUAL   = 6'd10;
  localparam logic [KIND_BITS-1:0] K_CARET       = 6'd13;
  localparam logic [KIND_BITS-1:0] K_FSLASH      = 6'd16;
  localparam logic [KIND_BITS-1:0] K_FSLASHEQUAL = 6'd17;
  localparam logic [KIND_BITS-1:0] K_LPAREN      = 6'd19;
  localparam logic [KIND_BITS-1:0] K_RPAREN      = 6'd20;
  localparam logic [KIND_BITS-1:0] K_LBRACKET    = 6'd21;
  localparam logic [KIND_BITS-1:0] K_RBRACKET    = 6'd22;
  localparam logic [KIND_BITS-1:0] K_LBRACE      = 6'd23;
  localparam logic [KIND_BITS-1:0] K_RBRACE      = 6'd24;
  localparam logic [KIND_BITS-1:0] K_EQUAL       = 6'd25;
  localparam logic [KIND_BITS-1:0] K_EQUALEQUAL  = 6'd26;
  localparam logic [KIND_BITS-1:0] K_COMMA       = 6'd27;
  localparam logic [KIND_BITS-1:0] K_COLON       = 6'd28;
  localparam logic [KIND_BITS-1:0] K_COLONEQUAL  = 6'd29;
  localparam logic [KIND_BITS-1:0] K_SEMI        = 6'd31;
  localparam logic [KIND_BITS-1:0] K_ENDMARKER   = 6'd36;
  localparam logic [KIND_BITS-1:0] K_ERROR       = 6'd37;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [POS_BITS-1:0]  start;
    logic [POS_BITS-1:0]  stop;
    logic [LINE_BITS-1:0] line;
    logic                 zero_pfx;
    logic                 run_last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_USCORE);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_quote(input logic [7:0] b);
    return (b == CH_DQUOTE) || (b == CH_SQUOTE);
  endfunction

  function automatic logic [KIND_BITS-1:0] pair_kind(input logic [7:0] b);
    logic [KIND_BITS-1:0] k;
    unique case (b)
      CH_EQ:    k = K_EQUALEQUAL;
      CH_PLUS:  k = K_PLUSEQUAL;
      CH_MINUS: k = K_MINUSEQUAL;
      CH_STAR:  k = K_STAREQUAL;
      CH_SLASH: k = K_FSLASHEQUAL;
      CH_CARET: k = K_CARET;
      CH_COLON: k = K_COLONEQUAL;
      default:  k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] b);
    logic [KIND_BITS-1:0] k;
    unique case (b)
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACK: k = K_LBRACKET;
      CH_RBRACK: k = K_RBRACKET;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_COMMA:  k = K_COMMA;
      CH_SEMI:   k = K_SEMI;
      CH_COLON:  k = K_COLON;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_FSLASH;
      CH_CARET:  k = K_CARET;
      CH_EQ:     k = K_EQUAL;
      default:   k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] v);
    return (&v) ? v : v + POS_BITS'(1);
  endfunction

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
    return (&v) ? v : v + LINE_BITS'(1);
  endfunction

  function automatic tok_t mk_tok(input logic [KIND_BITS-1:0] kind,
                                  input logic [POS_BITS-1:0]  s,
                                  input logic [POS_BITS-1:0]  e,
                                  input logic [LINE_BITS-1:0] line,
                                  input logic                 zp);
    tok_t t;
    t.kind     = kind;
    t.start    = s;
    t.stop     = e;
    t.line     = line;
    t.zero_pfx = zp;
    t.run_last = 1'b0;
    return t;
  endfunction

endpackage

>>> src/expression_tokenizer.sv
// Streaming byte tokenizer: scanner state, per-beat token logic and result queue.
// The results of an accepted byte are registered in the result queue and go out in order from its head.
// Throughput: one byte per cycle while the result queue has room for three results;
//   results leave at one per cycle while out_ready is high, so a byte that causes two or three stalls the input.
// Reset (rst_n low, synchronous): scanner idle, offset 0, line 1, result queue empty.
// After the end-of-text byte the scanner returns to its reset state for the next text.
module expression_tokenizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_text_byte,
  input  logic                              in_end_of_text,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [exptok_pkg::KIND_BITS-1:0]  out_token_kind,
  output logic [exptok_pkg::POS_BITS-1:0]   out_start_offset,
  output logic [exptok_pkg::POS_BITS-1:0]   out_end_offset,
  output logic [exptok_pkg::LINE_BITS-1:0]  out_line_number,
  output logic                              out_zero_prefixed,
  output logic                              out_run_last
);
  import exptok_pkg::*;

  // Scanner modes
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_INT     = 3'd2;
  localparam logic [2:0] M_DOT     = 3'd3;
  localparam logic [2:0] M_FRAC    = 3'd4;
  localparam logic [2:0] M_STRING  = 3'd5;
  localparam logic [2:0] M_IDENT   = 3'd6;
  localparam logic [2:0] M_OPER    = 3'd7;

  localparam int MAX_RES = 3;
  localparam int DEPTH   = 4;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int RN_W    = $clog2(MAX_RES + 1);

  // Scanner state
  logic [2:0]           mode_r,  mode_nxt;
  logic [POS_BITS-1:0]  tstart_r, tstart_nxt;
  logic [POS_BITS-1:0]  pos_r,   pos_nxt;
  logic [LINE_BITS-1:0] line_r,  line_nxt;
  logic [7:0]           hop_r,   hop_nxt;
  logic                 hid_r,   hid_nxt;

  // Result queue
  tok_t               q_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  // Per-beat results
  tok_t               res [MAX_RES];
  logic [RN_W-1:0]    res_n;

  logic in_fire, out_fire;

  // Accept a beat only when all three possible results fit.
  assign in_ready  = (cnt_r <= CNT_W'(DEPTH - MAX_RES));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;

  // Close the pending token of mode md at end position e.
  function automatic logic close_vld(input logic [2:0] md);
    return (md != M_IDLE) && (md != M_COMMENT);
  endfunction

  function automatic tok_t close_tok(input logic [2:0]           md,
                                     input logic [POS_BITS-1:0]  ts,
                                     input logic [POS_BITS-1:0]  e,
                                     input logic [LINE_BITS-1:0] lc,
                                     input logic                 hid,
                                     input logic [7:0]           hop);
    tok_t t;
    unique case (md)
      M_INT:    t = mk_tok(K_NUMBER, ts, e, lc, 1'b0);
      M_DOT:    t = mk_tok(K_ERROR, ts, e, lc, 1'b0);
      M_FRAC:   t = mk_tok(K_NUMBER, ts, e, lc, !hid);
      M_STRING: t = mk_tok(K_STRING, ts, e, lc, 1'b0);
      M_IDENT:  t = mk_tok(K_ID, ts, e, lc, 1'b0);
      M_OPER:   t = mk_tok(single_kind(hop), ts, pos_inc(ts), lc, 1'b0);
      default:  t = mk_tok(K_NONE, ts, e, lc, 1'b0);
    endcase
    return t;
  endfunction

  // Token logic for one beat: up to three results and the next scanner state.
  always_comb begin
    logic [7:0]          b;
    logic [POS_BITS-1:0] np;
    logic                fresh;
    b          = in_text_byte;
    np         = pos_inc(pos_r);
    fresh      = 1'b0;
    mode_nxt   = mode_r;
    tstart_nxt = tstart_r;
    line_nxt   = line_r;
    hop_nxt    = hop_r;
    hid_nxt    = hid_r;
    pos_nxt    = np;
    res_n      = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = mk_tok(K_NONE, '0, '0, '0, 1'b0);
    end

    // Continue or close the pending token.
    unique case (mode_r)
      M_COMMENT: begin
        if (b == CH_NL) begin
          mode_nxt = M_IDLE;
          fresh    = 1'b1;
        end
      end
      M_INT: begin
        if (b == CH_DOT) begin
          mode_nxt = M_DOT;
        end else if (!is_digit(b)) begin
          fresh = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit(b)) begin
          mode_nxt = M_FRAC;
        end else begin
          fresh = 1'b1;
        end
      end
      M_FRAC: begin
        if (!is_digit(b)) fresh = 1'b1;
      end
      M_STRING: begin
        if (is_quote(b)) begin
          res[res_n[1:0]] = close_tok(mode_r, tstart_r, pos_r, line_r, hid_r, hop_r);
          res_n    = res_n + RN_W'(1);
          mode_nxt = M_IDLE;
        end else if (b == CH_NL) begin
          line_nxt = line_inc(line_r);
        end
      end
      M_IDENT: begin
        if (!is_word(b)) fresh = 1'b1;
      end
      M_OPER: begin
        if (b == CH_EQ) begin
          res[res_n[1:0]] = mk_tok(pair_kind(hop_r), tstart_r, np, line_r, 1'b0);
          res_n    = res_n + RN_W'(1);
          mode_nxt = M_IDLE;
        end else begin
          fresh = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase

    // A breaking byte closes the token in progress (comment and idle emit nothing).
    if (fresh) begin
      if (close_vld(mode_r)) begin
        res[res_n[1:0]] = close_tok(mode_r, tstart_r, pos_r, line_r, hid_r, hop_r);
        res_n = res_n + RN_W'(1);
      end
      mode_nxt = M_IDLE;
    end

    // Start a fresh token from this byte.
    if (fresh) begin
      priority if (is_space(b)) begin
        if (b == CH_NL) line_nxt = line_inc(line_r);
      end else if (b == CH_HASH) begin
        mode_nxt = M_COMMENT;
      end else if (is_digit(b)) begin
        mode_nxt   = M_INT;
        tstart_nxt = pos_r;
        hid_nxt    = 1'b1;
      end else if (b == CH_DOT) begin
        mode_nxt   = M_DOT;
        tstart_nxt = pos_r;
        hid_nxt    = 1'b0;
      end else if (is_quote(b)) begin
        mode_nxt   = M_STRING;
        tstart_nxt = np;
      end else if (is_alpha(b) || (b == CH_USCORE)) begin
        mode_nxt   = M_IDENT;
        tstart_nxt = pos_r;
      end else if (pair_kind(b) != K_NONE) begin
        mode_nxt   = M_OPER;
        tstart_nxt = pos_r;
        hop_nxt    = b;
      end else begin
        res[res_n[1:0]] = mk_tok(single_kind(b), pos_r, np, line_r, 1'b0);
        res_n = res_n + RN_W'(1);
      end
    end

    // End of text: close what is open, add the end marker, drop back to reset state.
    if (in_end_of_text) begin
      if (close_vld(mode_nxt)) begin
        res[res_n[1:0]] = close_tok(mode_nxt, tstart_nxt, np, line_nxt, hid_nxt, hop_nxt);
        res_n = res_n + RN_W'(1);
      end
      res[res_n[1:0]] = mk_tok(K_ENDMARKER, '0, '0, line_inc(line_nxt), 1'b0);
      res_n      = res_n + RN_W'(1);
      mode_nxt   = M_IDLE;
      tstart_nxt = '0;
      pos_nxt    = '0;
      line_nxt   = LINE_BITS'(1);
      hop_nxt    = '0;
      hid_nxt    = 1'b0;
    end

    // Flag the last result of this beat.
    if (res_n != '0) begin
      res[2'(res_n - RN_W'(1))].run_last = 1'b1;
    end
  end

  // Scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      tstart_r <= '0;
      pos_r    <= '0;
      line_r   <= LINE_BITS'(1);
      hop_r    <= '0;
      hid_r    <= 1'b0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      tstart_r <= tstart_nxt;
      pos_r    <= pos_nxt;
      line_r   <= line_nxt;
      hop_r    <= hop_nxt;
      hid_r    <= hid_nxt;
    end
  end

  // Queue storage: push the beat's results in order.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < MAX_RES; i++) begin
        if (RN_W'(i) < res_n) q_r[wr_ptr_r + PTR_W'(i)] <= res[i];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire)  cnt_nxt = cnt_nxt + CNT_W'(res_n);
    if (out_fire) cnt_nxt = cnt_nxt - CNT_W'(1);
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire)  wr_ptr_r <= wr_ptr_r + PTR_W'(res_n);
      if (out_fire) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Head of queue drives the result beat.
  assign out_token_kind    = q_r[rd_ptr_r].kind;
  assign out_start_offset  = q_r[rd_ptr_r].start;
  assign out_end_offset    = q_r[rd_ptr_r].stop;
  assign out_line_number   = q_r[rd_ptr_r].line;
  assign out_zero_prefixed = q_r[rd_ptr_r].zero_pfx;
  assign out_run_last      = q_r[rd_ptr_r].run_last;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("result queue overfilled");

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    line_r != '0)
    else $error("line count reached zero");

  a_eot_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_end_of_text |=>
      (mode_r == M_IDLE) && (pos_r == '0) && (line_r == LINE_BITS'(1)) && (cnt_r != '0))
    else $error("end of text did not restore scanner state or queue end marker");

  a_endmarker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == K_ENDMARKER) |->
      out_run_last && (out_start_offset == '0) && (out_end_offset == '0))
    else $error("malformed end marker");
`endif

endmodule

>>> tb/expression_tokenizer_tb.sv
// Self-checking testbench for the streaming expression tokenizer.
module expression_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import exptok_pkg::*;

  // Byte sets the random text builder draws from.
  localparam logic [7:0] CH_VTAB  = 8'h0B;
  localparam logic [7:0] CH_FFEED = 8'h0C;
  localparam logic [7:0] PAIR_CHARS [7] = '{CH_EQ, CH_PLUS, CH_MINUS, CH_STAR,
                                            CH_SLASH, CH_CARET, CH_COLON};
  localparam logic [7:0] SINGLE_CHARS [15] = '{CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK,
                                               CH_LBRACE, CH_RBRACE, CH_COMMA, CH_SEMI,
                                               CH_COLON, CH_PLUS, CH_MINUS, CH_STAR,
                                               CH_SLASH, CH_CARET, CH_EQ};
  localparam logic [7:0] BLANK_CHARS [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_CR,
                                             CH_VTAB, CH_FFEED};

  // Token predictor plus the queue of tokens still owed by the block.
  class token_scoreboard;
    typedef enum logic [2:0] {
      SC_IDLE, SC_COMMENT, SC_INT, SC_DOT, SC_FRAC, SC_STRING, SC_IDENT, SC_OPER
    } scan_e;

    scan_e           mode;
    logic [15:0]     tok_start;
    logic [15:0]     pos;
    logic [15:0]     lines;
    logic [7:0]      held_op;
    bit              int_digits;
    tok_t            owed_q[$];
    int              errors;
    int              checked;

    function new();
      clear();
      errors  = 0;
      checked = 0;
    endfunction

    function void clear();
      mode       = SC_IDLE;
      tok_start  = '0;
      pos        = '0;
      lines      = 16'd1;
      held_op    = '0;
      int_digits = 0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function bit digit(logic [7:0] b);
      return b inside {[8'h30:8'h39]};
    endfunction

    function bit letter(logic [7:0] b);
      return (b inside {[8'h41:8'h5A]}) || (b inside {[8'h61:8'h7A]});
    endfunction

    function bit blank(logic [7:0] b);
      return (b == CH_SPACE) || (b inside {[8'h09:8'h0D]});
    endfunction

    function bit quote(logic [7:0] b);
      return (b == CH_SQUOTE) || (b == CH_DQUOTE);
    endfunction

    function logic [5:0] pair_code(logic [7:0] b);
      case (b)
        CH_EQ:    return K_EQUALEQUAL;
        CH_PLUS:  return K_PLUSEQUAL;
        CH_MINUS: return K_MINUSEQUAL;
        CH_STAR:  return K_STAREQUAL;
        CH_SLASH: return K_FSLASHEQUAL;
        CH_CARET: return K_CARET;
        CH_COLON: return K_COLONEQUAL;
        default:  return K_NONE;
      endcase
    endfunction

    function logic [5:0] single_code(logic [7:0] b);
      case (b)
        CH_LPAREN: return K_LPAREN;
        CH_RPAREN: return K_RPAREN;
        CH_LBRACK: return K_LBRACKET;
        CH_RBRACK: return K_RBRACKET;
        CH_LBRACE: return K_LBRACE;
        CH_RBRACE: return K_RBRACE;
        CH_COMMA:  return K_COMMA;
        CH_SEMI:   return K_SEMI;
        CH_COLON:  return K_COLON;
        CH_PLUS:   return K_PLUS;
        CH_MINUS:  return K_MINUS;
        CH_STAR:   return K_STAR;
        CH_SLASH:  return K_FSLASH;
        CH_CARET:  return K_CARET;
        CH_EQ:     return K_EQUAL;
        default:   return K_NONE;
      endcase
    endfunction

    function void owe(logic [5:0] kind, logic [15:0] s, logic [15:0] e,
                      logic [15:0] ln, bit zp);
      tok_t t;
      t.kind     = kind;
      t.start    = s;
      t.stop     = e;
      t.line     = ln;
      t.zero_pfx = zp;
      t.run_last = 1'b0;
      owed_q.push_back(t);
    endfunction

    // Close whatever token is open, ending it at end_pos.
    function void flush(logic [15:0] end_pos);
      case (mode)
        SC_INT:    owe(K_NUMBER, tok_start, end_pos, lines, 0);
        SC_DOT:    owe(K_ERROR, tok_start, end_pos, lines, 0);
        SC_FRAC:   owe(K_NUMBER, tok_start, end_pos, lines, !int_digits);
        SC_STRING: owe(K_STRING, tok_start, end_pos, lines, 0);
        SC_IDENT:  owe(K_ID, tok_start, end_pos, lines, 0);
        SC_OPER:   owe(single_code(held_op), tok_start, bump(tok_start), lines, 0);
        default: ;
      endcase
      mode = SC_IDLE;
    endfunction

    // Byte arriving with no token open.
    function void open_token(logic [7:0] b, logic [15:0] p, logic [15:0] np);
      if (blank(b)) begin
        if (b == CH_NL) lines = bump(lines);
      end else if (b == CH_HASH) begin
        mode = SC_COMMENT;
      end else if (digit(b)) begin
        mode = SC_INT; tok_start = p; int_digits = 1;
      end else if (b == CH_DOT) begin
        mode = SC_DOT; tok_start = p; int_digits = 0;
      end else if (quote(b)) begin
        mode = SC_STRING; tok_start = np;
      end else if (letter(b) || b == CH_USCORE) begin
        mode = SC_IDENT; tok_start = p;
      end else if (pair_code(b) != K_NONE) begin
        mode = SC_OPER; tok_start = p; held_op = b;
      end else begin
        owe(single_code(b), p, np, lines, 0);
      end
    endfunction

    // Accepted input beat: advance the scanner and queue the tokens it causes.
    function void note_byte(logic [7:0] b, logic last);
      logic [15:0] p;
      logic [15:0] np;
      bit          fresh;
      int          base;
      base  = owed_q.size();
      p     = pos;
      np    = bump(pos);
      fresh = 0;
      case (mode)
        SC_COMMENT: if (b == CH_NL) begin mode = SC_IDLE; fresh = 1; end
        SC_INT: begin
          if (b == CH_DOT) mode = SC_DOT;
          else if (!digit(b)) begin flush(p); fresh = 1; end
        end
        SC_DOT: begin
          if (digit(b)) mode = SC_FRAC;
          else begin flush(p); fresh = 1; end
        end
        SC_FRAC: if (!digit(b)) begin flush(p); fresh = 1; end
        SC_STRING: begin
          if (quote(b)) flush(p);
          else if (b == CH_NL) lines = bump(lines);
        end
        SC_IDENT: if (!(letter(b) || digit(b) || b == CH_USCORE)) begin
          flush(p); fresh = 1;
        end
        SC_OPER: begin
          if (b == CH_EQ) begin
            owe(pair_code(held_op), tok_start, np, lines, 0);
            mode = SC_IDLE;
          end else begin
            flush(p); fresh = 1;
          end
        end
        default: fresh = 1;
      endcase
      if (fresh) open_token(b, p, np);
      pos = np;
      if (last) begin
        flush(np);
        owe(K_ENDMARKER, '0, '0, bump(lines), 0);
        clear();
      end
      if (owed_q.size() > base) owed_q[owed_q.size()-1].run_last = 1'b1;
    endfunction

    function void check_token(tok_t got);
      tok_t want;
      if (owed_q.size() == 0) begin
        $error("token with none owed: token_kind %0d start_offset %0d end_offset %0d",
               got.kind, got.start, got.stop);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      if (got.kind !== want.kind) begin
        $error("token_kind expected %0d actual %0d", want.kind, got.kind); errors++;
      end
      if (got.start !== want.start) begin
        $error("start_offset expected %0d actual %0d", want.start, got.start); errors++;
      end
      if (got.stop !== want.stop) begin
        $error("end_offset expected %0d actual %0d", want.stop, got.stop); errors++;
      end
      if (got.line !== want.line) begin
        $error("line_number expected %0d actual %0d", want.line, got.line); errors++;
      end
      if (got.zero_pfx !== want.zero_pfx) begin
        $error("zero_prefixed expected %0d actual %0d", want.zero_pfx, got.zero_pfx);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $error("run_last expected %0d actual %0d", want.run_last, got.run_last); errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_text_byte = '0;
  logic                 in_end_of_text = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIND_BITS-1:0] out_token_kind;
  logic [POS_BITS-1:0]  out_start_offset;
  logic [POS_BITS-1:0]  out_end_offset;
  logic [LINE_BITS-1:0] out_line_number;
  logic                 out_zero_prefixed;
  logic                 out_run_last;

  token_scoreboard tok_sb = new();

  int         idle_pct = 0;   // chance per cycle that the sender sits idle
  int         stall_pct = 0;  // chance per cycle that the receiver stalls
  int         hold_left = 0;  // cycles of forced receiver hold-off still to run
  int         bytes_sent = 0;
  int         texts_sent = 0;
  logic [7:0] text_q[$];

  expression_tokenizer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_text_byte      (in_text_byte),
    .in_end_of_text    (in_end_of_text),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_kind    (out_token_kind),
    .out_start_offset  (out_start_offset),
    .out_end_offset    (out_end_offset),
    .out_line_number   (out_line_number),
    .out_zero_prefixed (out_zero_prefixed),
    .out_run_last      (out_run_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: a requested hold-off wins; otherwise stall at random.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: feed accepted input beats to the predictor, check accepted token beats.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tok_sb.note_byte(in_text_byte, in_end_of_text);
      if (out_valid && out_ready)
        tok_sb.check_token(tok_t'{out_token_kind, out_start_offset, out_end_offset,
                                  out_line_number, out_zero_prefixed, out_run_last});
    end
  end

  // Offer one byte and hold it until the block takes it. Valid stays high into the
  // next byte unless an idle gap is drawn, so it is never dropped and raised in one step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (last) texts_sent++;
  endtask

  task automatic send_string(input string s, input logic ends_text);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], ends_text && (i == s.len() - 1));
  endtask

  // Drop valid and hold until every owed token has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tok_sb.owed_q.size() != 0);
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'((($urandom_range(1) != 0) ? 8'h61 : 8'h41) + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(9));
  endfunction

  // Append one well-formed token, or some noise, to the text being built.
  task automatic add_token();
    logic [7:0] c;
    int         n;
    case ($urandom_range(10))
      0: begin  // identifier
        text_q.push_back(($urandom_range(3) == 0) ? CH_USCORE : rand_letter());
        repeat ($urandom_range(4)) begin
          case ($urandom_range(2))
            0:       text_q.push_back(rand_letter());
            1:       text_q.push_back(rand_digit());
            default: text_q.push_back(CH_USCORE);
          endcase
        end
      end
      1: repeat ($urandom_range(1, 4)) text_q.push_back(rand_digit());
      2: begin  // number with a fraction
        repeat ($urandom_range(1, 3)) text_q.push_back(rand_digit());
        text_q.push_back(CH_DOT);
        repeat ($urandom_range(1, 3)) text_q.push_back(rand_digit());
      end
      3: begin  // leading dot, gets the zero prefix
        text_q.push_back(CH_DOT);
        repeat ($urandom_range(1, 3)) text_q.push_back(rand_digit());
      end
      4: begin  // digits and a dot: an error token unless a digit happens to follow
        repeat ($urandom_range(0, 2)) text_q.push_back(rand_digit());
        text_q.push_back(CH_DOT);
      end
      5: begin  // string, either quote opens and closes, sometimes left open
        text_q.push_back(($urandom_range(1) != 0) ? CH_SQUOTE : CH_DQUOTE);
        n = $urandom_range(5);
        repeat (n) begin
          do c = 8'($urandom_range(255)); while (c == CH_SQUOTE || c == CH_DQUOTE);
          if ($urandom_range(5) == 0) c = CH_NL;
          text_q.push_back(c);
        end
        if ($urandom_range(6) != 0)
          text_q.push_back(($urandom_range(1) != 0) ? CH_SQUOTE : CH_DQUOTE);
      end
      6: begin  // comment up to a newline
        text_q.push_back(CH_HASH);
        repeat ($urandom_range(4)) begin
          do c = 8'($urandom_range(255)); while (c == CH_NL);
          text_q.push_back(c);
        end
        text_q.push_back(CH_NL);
      end
      7: begin  // operator followed by '='
        text_q.push_back(PAIR_CHARS[$urandom_range(6)]);
        text_q.push_back(CH_EQ);
      end
      8: text_q.push_back(SINGLE_CHARS[$urandom_range(14)]);
      9: text_q.push_back(BLANK_CHARS[$urandom_range(5)]);
      default: text_q.push_back(8'($urandom_range(255)));
    endcase
  endtask

  task automatic build_text();
    text_q.delete();
    repeat ($urandom_range(2, 9)) begin
      add_token();
      // Separate half the tokens so both glued and spaced transitions occur.
      if ($urandom_range(1) != 0) text_q.push_back(($urandom_range(3) == 0) ? CH_NL : CH_SPACE);
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input int quota, input int hold);
    int sent;
    idle_pct  = idle;
    stall_pct = stall;
    hold_left = hold;
    sent      = 0;
    while (sent < quota) begin
      build_text();
      sent += text_q.size();
      foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: bad fraction, leading dot, lone dot, string across a newline closed by
    // the other quote, comment, caret-equal, zero and high bytes, open string at the end.
    send_string("12.x .5 . 'a\n\"#c\n_9^=", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_string("\"z", 1'b1);
    // Operator pending at end of text, then a one-digit text.
    send_string("+", 1'b1);
    send_string("7", 1'b1);
    wait_drained();

    // Random texts under each idling pattern; the first and third also force a long hold-off
    // while bytes keep coming so the result queue fills and in_ready drops.
    run_phase(0, 0, 40, 60);
    run_phase(78, 0, 40, 0);
    run_phase(0, 78, 40, 40);
    run_phase(32, 32, 40, 0);

    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in %0d texts; %0d tokens checked", bytes_sent, texts_sent,
             tok_sb.checked);
    $display("across directed corner texts, idle, stall, long hold-off and drain phases.");
    if (tok_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
